### sv/pfu_pkg.sv
// shared constants, types and helpers of the pairwise force particle update block
`default_nettype none

package pfu_pkg;

    // store depth default
    localparam int MAX_SOURCES = 1024;

    // field widths
    localparam int POS_W   = 24;
    localparam int IDX_W   = 10;
    localparam int G_W     = 18;
    localparam int RAD_W   = 19;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 19;
    localparam int TDATA_W = 112;

    // datapath widths
    localparam int DIFF_W     = POS_W + 1;
    localparam int PROD_W     = DIFF_W + G_W;
    localparam int NUM_W      = 42;
    localparam int DEN_W      = 27;
    localparam int ACC_W      = 44;
    localparam int ROOT_W     = 25;
    localparam int ROOT_IN_W  = 2 * ROOT_W;
    localparam int ROOT_REM_W = ROOT_W + 1;

    // interaction limits and walls, 8 fraction bits
    localparam logic [ROOT_W-1:0] NEAR_LIMIT  = ROOT_W'(3072);
    localparam logic signed [POS_W-1:0] WALL_X_HIGH = POS_W'(355840);
    localparam logic signed [POS_W-1:0] WALL_Y_HIGH = POS_W'(304640);
    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    // damping by 0.8: times four, then divided by five as a reciprocal multiply
    // (2^30 + 1) / 5, exact for every dividend below 2^30
    localparam int                DAMP_W     = 28;
    localparam int                DAMP_SHIFT = 30;
    localparam logic [DAMP_W-1:0] DAMP_MUL   = DAMP_W'(214748365);

    // reset values of the registers
    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(116480);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_STRENGTH = 2'd0,
        CFG_RADIUS   = 2'd1,
        CFG_COUNT    = 2'd2
    } t_cfg_idx;

    // operation codes
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    // handshake between sequencer and divider
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic done;
    } t_div_stat;

    // saturate a wide signed value to a position word
    function automatic logic signed [POS_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [POS_W-1:0] res;
        if (v > ACC_W'(POS_MAX)) begin
            res = POS_MAX;
        end else if (v < ACC_W'(POS_MIN)) begin
            res = POS_MIN;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### sv/pfu_ram.sv
// generic single port ram with registered read
`default_nettype none

module pfu_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

### sv/pfu_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module pfu_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire pfu_pkg::t_div_ctrl        i_ctrl,
    input  wire logic [pfu_pkg::NUM_W-1:0] i_num,
    input  wire logic [pfu_pkg::DEN_W-1:0] i_den,
    output pfu_pkg::t_div_stat             o_stat,
    output logic      [pfu_pkg::NUM_W-1:0] o_quo
);

    localparam int NW = pfu_pkg::NUM_W;
    localparam int DW = pfu_pkg::DEN_W;
    localparam int CW = $clog2(NW);

    logic [DW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic          w_ge;

    // one shift and trial subtract
    always_comb begin
        w_trial = {r_rem, r_quo[NW-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
        n_quo   = {r_quo[NW-2:0], w_ge};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

### sv/pairwise_force_particle_update_top.sv
// top level of the pairwise force particle update block
`default_nettype none

// Load items (tuser 0) write one source position into the store, so loads can
// follow back to back. An update item (tuser 1) walks the first source_count
// store entries one at a time: a store read, difference, squares and force
// products, a bit-pair square root and a band check. For sources inside the
// interaction band both force products go through a 42-bit restoring divide
// in parallel, and the signed quotients are then accumulated. Damping by 0.8
// is a reciprocal multiply. The next item can be taken in the cycle the result
// is presented. The result waits in an output register, so the next item is
// taken while it is still unread; only a second finished update waits for it.
// The store has no reset; source entries must be loaded before they take part.
module pairwise_force_particle_update_top #(
    parameter int MAX_SOURCES = pfu_pkg::MAX_SOURCES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // fields: index[9:0], pos_x[33:10], pos_y[57:34], vel_x[81:58],
    // vel_y[105:82], write_back[106]
    input  wire logic [pfu_pkg::TDATA_W-1:0] i_s_tdata,
    // fields: operation[0]
    input  wire logic                        i_s_tuser,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // fields: target_index[9:0], new_pos_x[33:10], new_pos_y[57:34],
    // new_vel_x[81:58], new_vel_y[105:82]
    output logic      [pfu_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [pfu_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW  = $clog2(MAX_SOURCES);
    localparam int CW  = $clog2(MAX_SOURCES + 1);
    localparam int PW  = pfu_pkg::POS_W;
    localparam int DFW = pfu_pkg::DIFF_W;
    localparam int PRW = pfu_pkg::PROD_W;
    localparam int NW  = pfu_pkg::NUM_W;
    localparam int DNW = pfu_pkg::DEN_W;
    localparam int AC  = pfu_pkg::ACC_W;
    localparam int RW  = pfu_pkg::ROOT_W;
    localparam int RIW = pfu_pkg::ROOT_IN_W;
    localparam int RMW = pfu_pkg::ROOT_REM_W;
    localparam int RCW = $clog2(RW);
    localparam int MW  = pfu_pkg::DAMP_W;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_ADDR = 13'b0000000000010,
        S_READ = 13'b0000000000100,
        S_SQ   = 13'b0000000001000,
        S_SUM  = 13'b0000000010000,
        S_ROOT = 13'b0000000100000,
        S_CHK  = 13'b0000001000000,
        S_DIV  = 13'b0000010000000,
        S_ACC  = 13'b0000100000000,
        S_VEL  = 13'b0001000000000,
        S_FIN  = 13'b0010000000000,
        S_MOVE = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state r_state;

    // configuration registers
    logic signed [pfu_pkg::G_W-1:0]   r_strength;
    logic        [pfu_pkg::RAD_W-1:0] r_radius;
    logic        [pfu_pkg::CNT_W-1:0] r_count;

    // input fields
    logic [pfu_pkg::IDX_W-1:0] w_in_idx;
    logic signed [PW-1:0]      w_in_px, w_in_py;
    logic                      w_accept;
    logic                      w_in_idx_ok;

    // item registers
    logic [pfu_pkg::IDX_W-1:0] r_idx;
    logic signed [PW-1:0]      r_px, r_py, r_vx, r_vy;
    logic                      r_wb;
    logic                      r_idx_ok;
    logic [CW-1:0]             r_i, r_n;

    // per source datapath
    logic signed [DFW-1:0]     r_dx, r_dy;
    logic [2*PW-1:0]           r_sqx, r_sqy;
    logic signed [PRW-1:0]     r_mx, r_my;
    logic [RIW-1:0]            r_rad;
    logic [RMW-1:0]            r_rem;
    logic [RW-1:0]             r_root;
    logic [RCW-1:0]            r_rcnt;
    logic signed [AC-1:0]      r_fx, r_fy;
    logic                      r_sx, r_sy;
    logic [MW-1:0]             r_dmp_x, r_dmp_y;
    logic signed [PW-1:0]      r_nvx, r_nvy;
    logic signed [PW-1:0]      r_nx, r_ny;

    // divider interface
    pfu_pkg::t_div_ctrl        r_div_ctrl;
    pfu_pkg::t_div_stat        w_stat_x, w_stat_y;
    logic [NW-1:0]             r_num_x, r_num_y;
    logic [DNW-1:0]            r_den;
    logic [NW-1:0]             w_qx, w_qy;
    logic                      w_in_band;

    // store
    logic                      w_we;
    logic [AW-1:0]             w_addr;
    logic [2*PW-1:0]           w_wdata, w_rdata;

    // output register
    logic                      r_out_valid;
    logic [pfu_pkg::TDATA_W-1:0] r_out_data;

    // combinational helpers
    logic [RMW+1:0]            w_rtry, w_rtrial;
    logic signed [AC-1:0]      w_sum_x, w_sum_y, w_abs_x, w_abs_y;
    logic signed [AC-1:0]      w_qsx, w_qsy;
    logic [2*MW-1:0]           w_dpx, w_dpy;
    logic signed [AC-1:0]      w_dsx, w_dsy;
    logic signed [PW-1:0]      w_vx, w_vy, w_bx, w_by;
    logic signed [AC-1:0]      w_mvx, w_mvy;
    logic signed [PW-1:0]      w_nx, w_ny;

    assign w_in_idx    = i_s_tdata[9:0];
    assign w_in_px     = i_s_tdata[33:10];
    assign w_in_py     = i_s_tdata[57:34];
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_in_idx_ok = (32'(w_in_idx) < 32'(MAX_SOURCES));
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_in_band   = (r_root > pfu_pkg::NEAR_LIMIT) && (r_root < RW'(r_radius));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= '0;
            r_radius   <= pfu_pkg::RADIUS_RESET;
            r_count    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfu_pkg::CFG_STRENGTH: r_strength <= i_cfg_data[pfu_pkg::G_W-1:0];
                pfu_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[pfu_pkg::RAD_W-1:0];
                pfu_pkg::CFG_COUNT:    r_count    <= i_cfg_data[pfu_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // store port: load and write-back write, the walk reads
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_i[AW-1:0];
        w_wdata = {w_ny, w_nx};
        if (r_state == S_IDLE) begin
            w_addr  = AW'(w_in_idx);
            w_wdata = {w_in_py, w_in_px};
            w_we    = w_accept && (i_s_tuser == pfu_pkg::OP_LOAD) && w_in_idx_ok;
        end else if (r_state == S_MOVE) begin
            w_addr = AW'(r_idx);
            w_we   = r_wb && r_idx_ok;
        end
    end

    pfu_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_SOURCES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    pfu_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_div_ctrl),
        .i_num   (r_num_x),
        .i_den   (r_den),
        .o_stat  (w_stat_x),
        .o_quo   (w_qx)
    );

    pfu_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_div_ctrl),
        .i_num   (r_num_y),
        .i_den   (r_den),
        .o_stat  (w_stat_y),
        .o_quo   (w_qy)
    );

    // square root step, velocity sums, signed quotients, damping, move
    always_comb begin
        w_rtry   = {r_rem, r_rad[RIW-1 -: 2]};
        w_rtrial = {1'b0, r_root, 2'b01};
        w_sum_x  = AC'(r_vx) + r_fx;
        w_sum_y  = AC'(r_vy) + r_fy;
        w_abs_x  = w_sum_x[AC-1] ? -w_sum_x : w_sum_x;
        w_abs_y  = w_sum_y[AC-1] ? -w_sum_y : w_sum_y;
        w_qsx    = r_sx ? -$signed({2'b00, w_qx}) : $signed({2'b00, w_qx});
        w_qsy    = r_sy ? -$signed({2'b00, w_qy}) : $signed({2'b00, w_qy});
        w_dpx    = r_dmp_x * pfu_pkg::DAMP_MUL;
        w_dpy    = r_dmp_y * pfu_pkg::DAMP_MUL;
        w_dsx    = r_sx ? -$signed(AC'(w_dpx[2*MW-1:pfu_pkg::DAMP_SHIFT]))
                        :  $signed(AC'(w_dpx[2*MW-1:pfu_pkg::DAMP_SHIFT]));
        w_dsy    = r_sy ? -$signed(AC'(w_dpy[2*MW-1:pfu_pkg::DAMP_SHIFT]))
                        :  $signed(AC'(w_dpy[2*MW-1:pfu_pkg::DAMP_SHIFT]));
        w_vx     = pfu_pkg::sat24(w_dsx);
        w_vy     = pfu_pkg::sat24(w_dsy);
        w_bx     = pfu_pkg::sat24(-AC'(w_vx));
        w_by     = pfu_pkg::sat24(-AC'(w_vy));
        w_mvx    = AC'(r_px) + AC'(r_nvx);
        w_mvy    = AC'(r_py) + AC'(r_nvy);
        w_nx     = pfu_pkg::sat24(w_mvx);
        w_ny     = pfu_pkg::sat24(w_mvy);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_s_tuser == pfu_pkg::OP_UPDATE) begin
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: r_state <= (r_i == r_n) ? S_VEL : S_READ;
                S_READ: r_state <= S_SQ;
                S_SQ:   r_state <= S_SUM;
                S_SUM:  r_state <= S_ROOT;
                S_ROOT: begin
                    if (r_rcnt == RCW'(RW - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK:  r_state <= w_in_band ? S_DIV : S_ADDR;
                S_DIV: begin
                    if (w_stat_x.done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC:  r_state <= S_ADDR;
                S_VEL:  r_state <= S_FIN;
                S_FIN:  r_state <= S_MOVE;
                S_MOVE: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // divide start for a source inside the band
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_ctrl <= '0;
        end else begin
            r_div_ctrl.start <= (r_state == S_CHK) && w_in_band;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || i_m_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx       <= w_in_idx;
                r_px        <= w_in_px;
                r_py        <= w_in_py;
                r_vx        <= i_s_tdata[81:58];
                r_vy        <= i_s_tdata[105:82];
                r_wb        <= i_s_tdata[106];
                r_idx_ok    <= w_in_idx_ok;
                r_i         <= '0;
                r_fx        <= '0;
                r_fy        <= '0;
                r_n <= (32'(r_count) > 32'(MAX_SOURCES)) ? CW'(MAX_SOURCES) : CW'(r_count);
            end
            S_READ: begin
                r_dx <= DFW'(r_px) - DFW'($signed(w_rdata[PW-1:0]));
                r_dy <= DFW'(r_py) - DFW'($signed(w_rdata[2*PW-1:PW]));
            end
            S_SQ: begin
                r_sqx <= (2*PW)'(r_dx * r_dx);
                r_sqy <= (2*PW)'(r_dy * r_dy);
                r_mx  <= PRW'(r_dx * r_strength);
                r_my  <= PRW'(r_dy * r_strength);
            end
            S_SUM: begin
                r_rad  <= RIW'(r_sqx) + RIW'(r_sqy);
                r_rem  <= '0;
                r_root <= '0;
                r_rcnt <= '0;
            end
            S_ROOT: begin
                r_rad  <= {r_rad[RIW-3:0], 2'b00};
                r_rcnt <= r_rcnt + 1'b1;
                if (w_rtry >= w_rtrial) begin
                    r_rem  <= RMW'(w_rtry - w_rtrial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rtry[RMW-1:0];
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
            end
            S_CHK: begin
                r_i     <= r_i + 1'b1;
                r_den   <= {r_root[DNW-9:0], 8'b0};
                r_sx    <= r_mx[PRW-1];
                r_sy    <= r_my[PRW-1];
                r_num_x <= NW'(r_mx[PRW-1] ? -r_mx : r_mx);
                r_num_y <= NW'(r_my[PRW-1] ? -r_my : r_my);
            end
            S_ACC: begin
                r_fx <= r_fx + w_qsx;
                r_fy <= r_fy + w_qsy;
            end
            S_VEL: begin
                r_sx    <= w_sum_x[AC-1];
                r_sy    <= w_sum_y[AC-1];
                r_dmp_x <= {w_abs_x[MW-3:0], 2'b00};
                r_dmp_y <= {w_abs_y[MW-3:0], 2'b00};
            end
            S_FIN: begin
                r_nvx <= ((r_px < 0 && w_vx < 0) || (r_px > pfu_pkg::WALL_X_HIGH && w_vx > 0))
                         ? w_bx : w_vx;
                r_nvy <= ((r_py < 0 && w_vy < 0) || (r_py > pfu_pkg::WALL_Y_HIGH && w_vy > 0))
                         ? w_by : w_vy;
            end
            S_MOVE: begin
                r_nx <= w_nx;
                r_ny <= w_ny;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    r_out_data <= {6'b0, r_nvy, r_nvx, r_ny, r_nx, r_idx};
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // the walk never passes the source count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |-> (r_i <= r_n))
        else $error("source walk passed its count");

    // store writes only come from loads or write-back
    a_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE || r_state == S_MOVE))
        else $error("store written outside load or write-back");

    // both dividers finish together, and only while waited for
    a_div_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat_x.done |-> (w_stat_y.done && r_state == S_DIV))
        else $error("divider lanes out of step");

    // a divide starts only from the band check
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_ctrl.start |-> $past(r_state == S_CHK))
        else $error("divider started from wrong state");

endmodule

`default_nettype wire
